// ===== rtl/ocm_pkg.sv =====
// Shared types and constants for the orientation curvature map.
`timescale 1ns / 1ps
`default_nettype none
package ocm_pkg;

  typedef struct packed {
    logic [14:0] angle;
    logic        absent;
  } in_word_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [12:0] out_col;
    logic [14:0] bend;
    logic        bend_missing;
    logic        run_end;
    logic        frame_end;
  } out_word_t;

  // effective frame geometry plus a position clear pulse
  typedef struct packed {
    logic [15:0] len;
    logic [15:0] cnt;
    logic        clear;
  } geom_t;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [11:0] int_row;
    logic [12:0] int_col;
    logic [11:0] bord_row;
    logic [12:0] bord_col;
    logic        has_int;
    logic        has_bord;
    logic        int_ok;
    logic        frame_last;
    logic [14:0] cen;
    logic [14:0] fst;
    logic [14:0] snd;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  localparam int REG_LINE_LENGTH = 0;
  localparam int REG_LINE_COUNT  = 1;

  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int SINE_FULL    = 46080;

endpackage
`default_nettype wire

// ===== rtl/orientation_curvature_map.sv =====
// Top level of the orientation curvature map: register port and block wiring.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                               Word
// input     in_valid, in_stall, in_word         angle, absent
// output    out_valid, out_stall, out_word      row, col, bend, flags
// config    psel penable pwrite paddr pwdata    line_length @0, line_count @4
//
// One pixel per clock is accepted unless the job queue is full and the input
// stage holds a pixel; a pixel that yields both an interior and a border result
// holds the output slot for a second word. A pixel's first result passes the
// input stage, the queue, then the ten stage sine pipeline and the output slot.
// Reset clears positions and registers (512 x 512); the line stores need no
// clearing pass. Either side may stall at any time; the four word job queue
// lets the front keep going while the back waits.
module orientation_curvature_map #(
  parameter int MAX_LINE  = 2048,
  parameter int MAX_LINES = 4096
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ocm_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  wire                 out_stall,
  output ocm_pkg::out_word_t  out_word,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ocm_pkg::*;

  logic [11:0] line_length_r;
  logic [12:0] line_count_r;
  logic        wr;
  logic        reg_sel;
  geom_t       geom;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= 12'd512;
      line_count_r  <= 13'd512;
    end else if (wr) begin
      case (32'(reg_sel))
        REG_LINE_LENGTH: line_length_r <= pwdata[11:0];
        REG_LINE_COUNT:  line_count_r  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (32'(reg_sel))
      REG_LINE_LENGTH: prdata = {20'b0, line_length_r};
      REG_LINE_COUNT:  prdata = {19'b0, line_count_r};
      default:         prdata = '0;
    endcase
  end

  // clamp geometry into its legal range; a write restarts the frame
  always_comb begin
    if (32'(line_length_r) < 3) geom.len = 16'd3;
    else if (32'(line_length_r) > MAX_LINE) geom.len = 16'(MAX_LINE);
    else geom.len = 16'(line_length_r);
    if (32'(line_count_r) < 3) geom.cnt = 16'd3;
    else if (32'(line_count_r) > MAX_LINES) geom.cnt = 16'(MAX_LINES);
    else geom.cnt = 16'(line_count_r);
    geom.clear = wr;
  end

  logic   push, pop;
  job_t   push_job, head;
  qstat_t qstat;

  ocm_front #(.MAX_LINE(MAX_LINE), .MAX_LINES(MAX_LINES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .qstat    (qstat),
    .push     (push),
    .job      (push_job)
  );

  ocm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  ocm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// ===== rtl/ocm_front.sv =====
// Front: position tracking, line stores, 3x3 window and pixel classification.
`timescale 1ns / 1ps
`default_nettype none
module ocm_front #(
  parameter int MAX_LINE  = 2048,
  parameter int MAX_LINES = 4096
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ocm_pkg::geom_t      geom,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ocm_pkg::in_word_t   in_word,
  input  ocm_pkg::qstat_t     qstat,
  output logic                push,
  output ocm_pkg::job_t       job
);
  import ocm_pkg::*;

  localparam int RW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int CW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  logic [15:0]   s1_cur_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic [31:0]   rd_r;                 // {line b, line a}
  logic [31:0]   mem [MAX_LINE];
  logic [15:0]   win_r [3][3];
  logic [15:0]   nw [3][3];
  logic          acc, proc;
  logic          row_last, col_last;

  assign acc      = in_valid && !in_stall;
  assign in_stall = s1_valid_r && qstat.full;
  assign proc     = s1_valid_r && !qstat.full;

  assign row_last = (32'(row_r) == 32'(geom.len) - 1);
  assign col_last = (32'(col_r) == 32'(geom.cnt) - 1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (geom.clear) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (acc) begin
      if (row_last) begin
        row_nxt = '0;
        col_nxt = col_last ? '0 : col_r + 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) s1_valid_nxt = 1'b1;
    else if (proc) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // line store: read on accept, written back when the pixel moves on
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r     <= mem[row_r];
      s1_cur_r <= {in_word.absent, in_word.angle};
      s1_row_r <= row_r;
      s1_col_r <= col_r;
    end
    if (proc) mem[s1_row_r] <= {rd_r[15:0], s1_cur_r};
  end

  // window after the shift: oldest line at [0]
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nw[0][j] = win_r[1][j];
      nw[1][j] = win_r[2][j];
    end
    nw[2][0] = rd_r[31:16];
    nw[2][1] = rd_r[15:0];
    nw[2][2] = s1_cur_r;
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          win_r[i][j] <= nw[i][j];
    end
  end

  // classify: count present neighbours, keep first and last present
  logic [3:0]  npres;
  logic [14:0] fst, snd;
  logic        s_row_last, s_col_last, has_int, has_bord;

  always_comb begin
    npres = '0;
    fst   = '0;
    snd   = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (!(i == 1 && j == 1) && !nw[i][j][15]) begin
          if (npres == 4'd0) fst = nw[i][j][14:0];
          else snd = nw[i][j][14:0];
          npres = npres + 4'd1;
        end
  end

  assign s_row_last = (32'(s1_row_r) == 32'(geom.len) - 1);
  assign s_col_last = (32'(s1_col_r) == 32'(geom.cnt) - 1);
  assign has_int    = (32'(s1_row_r) >= 2) && (32'(s1_col_r) >= 2);
  assign has_bord   = (s1_row_r == '0) || (s1_col_r == '0) || s_row_last || s_col_last;

  assign push = proc && (has_int || has_bord);

  always_comb begin
    job.int_row    = 12'(s1_row_r);
    job.int_col    = 13'(s1_col_r);
    job.bord_row   = 12'(32'(s1_row_r) + 1);
    job.bord_col   = 13'(32'(s1_col_r) + 1);
    job.has_int    = has_int;
    job.has_bord   = has_bord;
    job.int_ok     = !nw[1][1][15] && (npres == 4'd2);
    job.frame_last = s_row_last && s_col_last;
    job.cen        = nw[1][1][14:0];
    job.fst        = fst;
    job.snd        = snd;
  end

endmodule
`default_nettype wire

// ===== rtl/ocm_queue.sv =====
// Short job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module ocm_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  ocm_pkg::job_t      push_job,
  input  wire                pop,
  output ocm_pkg::job_t      head,
  output ocm_pkg::qstat_t    qstat
);
  import ocm_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_pop;

  assign do_pop      = pop && (cnt_r != '0);
  assign head        = slot_r[rp_r];
  assign qstat.valid = (cnt_r != '0);
  assign qstat.full  = (cnt_r == (AW+1)'(DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_job;
  end

endmodule
`default_nettype wire

// ===== rtl/ocm_back.sv =====
// Back: angle sum, fixed-point sine pipeline and result sequencing.
`timescale 1ns / 1ps
`default_nettype none
module ocm_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ocm_pkg::job_t       head,
  input  ocm_pkg::qstat_t     qstat,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output ocm_pkg::out_word_t  out_word
);
  import ocm_pkg::*;

  localparam int NST    = 10;
  localparam int NH     = 5;
  localparam int RECIP  = 46604;  // ceil(2^21 / 45)

  typedef logic [31:0] hc_t [NH];
  localparam hc_t HORNER_C = '{32'd172272, 32'd5026995, 32'd85569305,
                               32'd693598668, 32'd1686629713};

  // floor((r * 2^20 + 22) / 45) for each remainder r
  function automatic logic [45*20-1:0] frac_build();
    logic [45*20-1:0] t;
    t = '0;
    for (int r = 0; r < 45; r++) t[r*20 +: 20] = 20'((r * (2 ** 20) + 22) / 45);
    return t;
  endfunction
  localparam logic [45*20-1:0] FRAC = frac_build();

  logic        en;
  logic        v_r [NST];
  job_t        m_r [NST];
  logic [15:0] u0_r, u1_r;
  logic [31:0] prod1_r;
  logic [30:0] x_r [7];   // stages 2..8
  logic [30:0] z_r [NH];  // stages 3..7
  logic [31:0] p_r [NH];  // stages 4..8
  logic [14:0] bend9_r;

  // wrapped differences and saturated magnitude
  logic signed [16:0] dl, dr;
  logic signed [17:0] ssum;
  logic [17:0]        sabs;
  logic [15:0]        u_in;

  always_comb begin
    dl = $signed({2'b00, head.cen}) - $signed({2'b00, head.snd});
    dr = $signed({2'b00, head.fst}) - $signed({2'b00, head.cen});
    if (dl > 17'sd11520) dl = dl - 17'sd23040;
    if (dl < -17'sd11520) dl = dl + 17'sd23040;
    if (dr > 17'sd11520) dr = dr - 17'sd23040;
    if (dr < -17'sd11520) dr = dr + 17'sd23040;
    ssum = 18'(dl) + 18'(dr);
    sabs = ssum[17] ? 18'(-ssum) : 18'(ssum);
    u_in = (sabs > 18'(SINE_FULL)) ? 16'(SINE_FULL) : sabs[15:0];
  end

  // stage 2: x = round(u * 2^30 / 46080) from quotient and remainder by 45
  logic [10:0] q2;
  logic [16:0] r2w;
  logic [5:0]  r2;
  assign q2  = prod1_r[31:21];
  assign r2w = 17'(u1_r) - 17'(q2) * 17'd45;
  assign r2  = r2w[5:0];

  logic [61:0] sq3;
  assign sq3 = 62'(x_r[0]) * 62'(x_r[0]);

  logic [62:0] hp [NH];
  always_comb begin
    hp[0] = 63'(32'd3864) * 63'(z_r[0]);
    for (int k = 1; k < NH; k++) hp[k] = 63'(p_r[k-1]) * 63'(z_r[k]);
  end

  logic [62:0] fp;
  logic [33:0] rnd;
  assign fp  = 63'(p_r[NH-1]) * 63'(x_r[6]);
  assign rnd = (34'(fp[62:30]) + 34'd16384) >> 15;

  // output slot with a pending border word
  logic      out_valid_r, pend_r;
  out_word_t out_r, bord_r;
  out_word_t int_w, bord_w;
  logic      slot_free;

  assign slot_free = !out_valid_r || (!out_stall && !pend_r);
  assign en        = slot_free;
  assign pop       = en && qstat.valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= qstat.valid;
      for (int k = 1; k < NST; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= head;
      for (int k = 1; k < NST; k++) m_r[k] <= m_r[k-1];
      u0_r    <= u_in;
      prod1_r <= 32'(u0_r) * 32'(RECIP);
      u1_r    <= u0_r;
      x_r[0]  <= 31'({q2, 20'b0}) + 31'(FRAC[r2*20 +: 20]);
      for (int k = 1; k < 7; k++) x_r[k] <= x_r[k-1];
      z_r[0]  <= sq3[60:30];
      for (int k = 1; k < NH; k++) z_r[k] <= z_r[k-1];
      for (int k = 0; k < NH; k++) p_r[k] <= HORNER_C[k] - hp[k][61:30];
      bend9_r <= (rnd > 34'd32767) ? 15'd32767 : rnd[14:0];
    end
  end

  always_comb begin
    int_w.out_row      = m_r[NST-1].int_row;
    int_w.out_col      = m_r[NST-1].int_col;
    int_w.bend         = m_r[NST-1].int_ok ? bend9_r : 15'd0;
    int_w.bend_missing = !m_r[NST-1].int_ok;
    int_w.run_end      = !m_r[NST-1].has_bord;
    int_w.frame_end    = !m_r[NST-1].has_bord && m_r[NST-1].frame_last;
    bord_w.out_row      = m_r[NST-1].bord_row;
    bord_w.out_col      = m_r[NST-1].bord_col;
    bord_w.bend         = 15'd0;
    bord_w.bend_missing = 1'b1;
    bord_w.run_end      = 1'b1;
    bord_w.frame_end    = m_r[NST-1].frame_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_valid_r && !out_stall && pend_r) begin
      pend_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= v_r[NST-1];
      pend_r      <= v_r[NST-1] && m_r[NST-1].has_int && m_r[NST-1].has_bord;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_stall && pend_r) begin
      out_r <= bord_r;
    end else if (slot_free) begin
      out_r  <= m_r[NST-1].has_int ? int_w : bord_w;
      bord_r <= bord_w;
    end
  end

endmodule
`default_nettype wire

// ===== sim/orientation_curvature_map_tb.sv =====
// Self-checking testbench for the orientation curvature map: random frames, stalls, checks.
`timescale 1ns / 1ps
`default_nettype none
module orientation_curvature_map_tb;
  import ocm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  orientation_curvature_map u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: register copies, two line stores, 3x3 window, position
  // ---------------------------------------------------------------------
  logic [11:0] reg_len = 12'd512;
  logic [12:0] reg_cnt = 13'd512;
  logic [15:0] prev_line [0:2047];
  logic [15:0] prev2_line [0:2047];
  logic [15:0] win [0:2][0:2];
  int unsigned row_at = 0, col_at = 0;

  out_word_t curv_expected [$];
  in_word_t pixel_queue [$];
  int mismatches = 0;
  int sent = 0;

  // idle controls set by the phase sequencer
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  function automatic int wrap_half(int d);
    if (d > QUARTER_TURN) d -= HALF_TURN;
    if (d < -QUARTER_TURN) d += HALF_TURN;
    return d;
  endfunction

  // 2*sin(pi*u/92160) in Q1.14, Horner Taylor series in Q30
  function automatic logic [14:0] sine_bend(longint unsigned u);
    longint unsigned x, z, p, r;
    x = ((u << 30) + SINE_FULL / 2) / SINE_FULL;
    z = (x * x) >> 30;
    p = 3864;
    p = 172272 - ((p * z) >> 30);
    p = 5026995 - ((p * z) >> 30);
    p = 85569305 - ((p * z) >> 30);
    p = 693598668 - ((p * z) >> 30);
    p = 1686629713 - ((p * z) >> 30);
    r = (((p * x) >> 30) + 16384) >> 15;
    if (r > 32767) r = 32767;
    return r[14:0];
  endfunction

  function automatic int unsigned eff_len();
    int unsigned v;
    v = 32'(reg_len);
    if (v < 3) v = 3;
    if (v > 2048) v = 2048;
    return v;
  endfunction

  function automatic int unsigned eff_cnt();
    int unsigned v;
    v = 32'(reg_cnt);
    if (v < 3) v = 3;
    if (v > 4096) v = 4096;
    return v;
  endfunction

  // Advance the predictor by one accepted pixel and queue its results.
  task automatic predict_pixel(input in_word_t px);
    int unsigned len, cnt, row, col, npresent;
    logic [15:0] cur, olda, oldb, c, v, first, second;
    int dl, dr, s;
    longint unsigned u;
    out_word_t r;
    int n;
    len = eff_len();
    cnt = eff_cnt();
    cur = {px.absent, px.angle};
    if (row_at >= len) row_at = 0;
    if (col_at >= cnt) col_at = 0;
    row = row_at;
    col = col_at;
    olda = prev_line[row];
    oldb = prev2_line[row];
    prev2_line[row] = olda;
    prev_line[row] = cur;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 3; j++) win[i][j] = win[i + 1][j];
    win[2][0] = oldb;
    win[2][1] = olda;
    win[2][2] = cur;
    n = 0;
    if (row >= 2 && col >= 2) begin
      r = '0;
      r.out_row = row[11:0];
      r.out_col = col[12:0];
      r.bend_missing = 1'b1;
      c = win[1][1];
      if (!c[15]) begin
        npresent = 0;
        first = '0;
        second = '0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            v = win[i][j];
            if (!(i == 1 && j == 1) && !v[15]) begin
              if (npresent == 0) first = v; else second = v;
              npresent++;
            end
          end
        if (npresent == 2) begin
          dl = wrap_half(int'(c[14:0]) - int'(second[14:0]));
          dr = wrap_half(int'(first[14:0]) - int'(c[14:0]));
          s = dl + dr;
          u = 64'((s < 0) ? -s : s);
          if (u > SINE_FULL) u = SINE_FULL;
          r.bend = sine_bend(u);
          r.bend_missing = 1'b0;
        end
      end
      curv_expected.push_back(r);
      n++;
    end
    if (row == 0 || row == len - 1 || col == 0 || col == cnt - 1) begin
      r = '0;
      r.out_row = 12'(row + 1);
      r.out_col = 13'(col + 1);
      r.bend_missing = 1'b1;
      curv_expected.push_back(r);
      n++;
    end
    if (n > 0) begin
      curv_expected[$].run_end = 1'b1;
      if (row == len - 1 && col == cnt - 1) curv_expected[$].frame_end = 1'b1;
    end
    row_at = row + 1;
    if (row_at >= len) begin
      row_at = 0;
      col_at = col + 1;
      if (col_at >= cnt) col_at = 0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers queued pixels; a held word never changes while stalled
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_pixel(in_word);
        sent <= sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word <= pixel_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted down one cycle at a time
  always @(posedge clk) begin
    if (rst_n && hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // ---------------------------------------------------------------------
  // Monitor / receiver: stalls at random, or holds off a long stretch
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (curv_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word row=%0d col=%0d", out_word.out_row,
                     out_word.out_col);
        end else begin
          out_word_t e;
          e = curv_expected.pop_front();
          if (e !== out_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word mismatch exp row=%0d col=%0d bend=%0d m=%0b re=%0b fe=%0b",
                       e.out_row, e.out_col, e.bend, e.bend_missing, e.run_end,
                       e.frame_end);
              $display("              got row=%0d col=%0d bend=%0d m=%0b re=%0b fe=%0b",
                       out_word.out_row, out_word.out_col, out_word.bend,
                       out_word.bend_missing, out_word.run_end, out_word.frame_end);
            end
          end
        end
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Register write: setup cycle then access cycle.
  task automatic write_reg(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LINE_LENGTH) reg_len = val[11:0];
    else reg_cnt = val[12:0];
    row_at = 0;
    col_at = 0;
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || curv_expected.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic in_word_t rand_pixel(int absent_pct);
    in_word_t p;
    case ($urandom_range(9))
      0: p.angle = 15'h7FFF;
      1: p.angle = 15'd23040;
      2: p.angle = 15'd0;
      3: p.angle = 15'($urandom_range(32767));
      default: p.angle = 15'($urandom_range(23040));
    endcase
    p.absent = ($urandom_range(99) < absent_pct);
    return p;
  endfunction

  // Push a run of count random pixels; sparse presence reaches the two-
  // neighbour curve case often.
  task automatic queue_pixels(input int count, input int absent_pct);
    for (int k = 0; k < count; k++) pixel_queue.push_back(rand_pixel(absent_pct));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x3 frame at the minimum size, extremes of the angle
    write_reg(REG_LINE_LENGTH, 3);
    write_reg(REG_LINE_COUNT, 3);
    pixel_queue.push_back('{angle: 15'd0, absent: 1'b1});
    pixel_queue.push_back('{angle: 15'd23040, absent: 1'b0});
    pixel_queue.push_back('{angle: 15'd0, absent: 1'b1});
    pixel_queue.push_back('{angle: 15'd0, absent: 1'b1});
    pixel_queue.push_back('{angle: 15'd11520, absent: 1'b0});
    pixel_queue.push_back('{angle: 15'd0, absent: 1'b1});
    pixel_queue.push_back('{angle: 15'd0, absent: 1'b1});
    pixel_queue.push_back('{angle: 15'h7FFF, absent: 1'b0});
    pixel_queue.push_back('{angle: 15'd0, absent: 1'b1});
    // all pixels present with alternating extreme angles: the all-present case
    for (int k = 0; k < 9; k++)
      pixel_queue.push_back('{angle: (k % 2) ? 15'h7FFF : 15'd0, absent: 1'b0});
    drain();

    // Out-of-range registers clamp to 3
    write_reg(REG_LINE_LENGTH, 0);
    write_reg(REG_LINE_COUNT, 32'h1FFF_E001);
    queue_pixels(9, 60);
    drain();

    // Random phases with varying idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      write_reg(REG_LINE_LENGTH, $urandom_range(3, 12));
      write_reg(REG_LINE_COUNT, $urandom_range(3, 9));
      queue_pixels(150, 65);
      if (ph == 0) begin
        hold_cycles = 120;  // long back-pressure while the sender keeps going
      end
      drain();
    end

    // Largest line and count registers, wide partial frame
    send_idle_pct = 0;
    recv_stall_pct = 13;
    write_reg(REG_LINE_COUNT, 4096);
    write_reg(REG_LINE_LENGTH, 2048);
    queue_pixels(30, 50);
    drain();
    write_reg(REG_LINE_LENGTH, 4095);
    queue_pixels(10, 50);
    drain();

    if (mismatches == 0 && curv_expected.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
